/* rtl/core/bis_pkg.sv */
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and defaults for the binary insertion sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int Q_DEPTH        = 2;
  localparam int Q_PW           = $clog2(Q_DEPTH);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } item_t;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SRCH_RD  = 8'b0000_0010,
    S_SRCH_CMP = 8'b0000_0100,
    S_SHIFT_RD = 8'b0000_1000,
    S_SHIFT_WR = 8'b0001_0000,
    S_PUT      = 8'b0010_0000,
    S_EMIT     = 8'b0100_0000,
    S_SPARE    = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/bis_front.sv */
// ----------------------------------------------------------------------------
// bis_front
// Accepts beats and holds them in a short queue for the sort engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [bis_pkg::VALUE_W-1:0] in_value,
  input  wire logic                               in_is_last,
  output logic                                    q_valid,
  output bis_pkg::item_t                          q_item,
  input  wire logic                               q_pop
);

  bis_pkg::item_t              entry_r [bis_pkg::Q_DEPTH];
  logic [bis_pkg::Q_PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [bis_pkg::Q_PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [bis_pkg::Q_PW:0]      fill_r, fill_nxt;
  logic                        push;
  logic                        pop;

  assign busy    = (fill_r == (bis_pkg::Q_PW+1)'(bis_pkg::Q_DEPTH));
  assign q_valid = (fill_r != '0);
  assign q_item  = entry_r[rd_ptr_r];
  assign push    = start && !busy;
  assign pop     = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == bis_pkg::Q_PW'(bis_pkg::Q_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == bis_pkg::Q_PW'(bis_pkg::Q_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= '{value: in_value, last: in_is_last};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bis_back.sv */
// ----------------------------------------------------------------------------
// bis_back
// Sort engine: binary search, shift-up and insert into the store, then
// streams the store out in ascending order on a last beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_back #(
  parameter int DEPTH      = bis_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bis_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               q_valid,
  input  wire bis_pkg::item_t                     q_item,
  output logic                                    q_pop,
  output logic                                    out_valid,
  output logic signed [bis_pkg::VALUE_W-1:0]      out_sorted_value,
  output logic                                    out_last_of_run,
  output logic                                    out_overflow
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] rd_data_r;

  bis_pkg::state_t state_r, state_nxt;
  logic signed [DATA_WIDTH-1:0] key_r, key_nxt;
  logic          last_r, last_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          ovf_r, ovf_nxt;
  logic          ov_valid_r, ov_valid_nxt;
  logic          ov_last_r, ov_last_nxt;
  logic          ov_ovf_r, ov_ovf_nxt;

  logic                  we, re;
  logic [IW-1:0]         wa, ra;
  logic signed [DATA_WIDTH-1:0] wd;
  logic [CW:0]           mid_sum;
  logic signed [63:0]    in_ext;
  logic signed [63:0]    out_ext;

  assign in_ext           = 64'($signed(q_item.value));
  assign out_ext          = 64'($signed(rd_data_r));
  assign mid_sum          = {1'b0, lo_r} + {1'b0, hi_r};
  assign out_valid        = ov_valid_r;
  assign out_last_of_run  = ov_last_r;
  assign out_overflow     = ov_ovf_r;
  assign out_sorted_value = out_ext[bis_pkg::VALUE_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    key_nxt      = key_r;
    last_nxt     = last_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    mid_nxt      = mid_r;
    j_nxt        = j_r;
    cnt_nxt      = cnt_r;
    k_nxt        = k_r;
    ovf_nxt      = ovf_r;
    ov_valid_nxt = 1'b0;
    ov_last_nxt  = 1'b0;
    ov_ovf_nxt   = ov_ovf_r;
    q_pop        = 1'b0;
    we           = 1'b0;
    wa           = '0;
    wd           = key_r;
    re           = 1'b0;
    ra           = '0;
    case (state_r)
      bis_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          key_nxt  = in_ext[DATA_WIDTH-1:0];
          last_nxt = q_item.last;
          if (cnt_r < CW'(DEPTH)) begin
            lo_nxt    = '0;
            hi_nxt    = cnt_r;
            state_nxt = bis_pkg::S_SRCH_RD;
          end else begin
            ovf_nxt = 1'b1;
            k_nxt   = '0;
            if (q_item.last) begin
              state_nxt = bis_pkg::S_EMIT;
            end
          end
        end
      end
      bis_pkg::S_SRCH_RD: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_sum[CW:1];
          re        = 1'b1;
          ra        = mid_sum[IW:1];
          state_nxt = bis_pkg::S_SRCH_CMP;
        end else begin
          j_nxt     = cnt_r;
          state_nxt = bis_pkg::S_SHIFT_RD;
        end
      end
      bis_pkg::S_SRCH_CMP: begin
        if (rd_data_r < key_r) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = bis_pkg::S_SRCH_RD;
      end
      bis_pkg::S_SHIFT_RD: begin
        if (j_r > lo_r) begin
          re        = 1'b1;
          ra        = IW'(j_r - 1'b1);
          state_nxt = bis_pkg::S_SHIFT_WR;
        end else begin
          state_nxt = bis_pkg::S_PUT;
        end
      end
      bis_pkg::S_SHIFT_WR: begin
        we        = 1'b1;
        wa        = j_r[IW-1:0];
        wd        = rd_data_r;
        j_nxt     = j_r - 1'b1;
        state_nxt = bis_pkg::S_SHIFT_RD;
      end
      bis_pkg::S_PUT: begin
        we      = 1'b1;
        wa      = lo_r[IW-1:0];
        wd      = key_r;
        cnt_nxt = cnt_r + 1'b1;
        k_nxt   = '0;
        if (last_r) begin
          state_nxt = bis_pkg::S_EMIT;
        end else begin
          state_nxt = bis_pkg::S_IDLE;
        end
      end
      bis_pkg::S_EMIT: begin
        re           = 1'b1;
        ra           = k_r[IW-1:0];
        ov_valid_nxt = 1'b1;
        ov_ovf_nxt   = ovf_r;
        k_nxt        = k_r + 1'b1;
        if (k_r == cnt_r - 1'b1) begin
          ov_last_nxt = 1'b1;
          cnt_nxt     = '0;
          ovf_nxt     = 1'b0;
          state_nxt   = bis_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bis_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bis_pkg::S_IDLE;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      ov_valid_r <= 1'b0;
      ov_last_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      ovf_r      <= ovf_nxt;
      ov_valid_r <= ov_valid_nxt;
      ov_last_r  <= ov_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    last_r   <= last_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    ov_ovf_r <= ov_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/binary_insertion_sorter_unit.sv */
// From accept to insert: pop, s search steps (read, compare; s at most ceil(log2(n+1))),
//   m shifts (read, write; m = entries shifted up), put.
// A last beat then streams n results on consecutive cycles, each read from the store in EMIT.
// The engine takes no new beat until the last is put or dropped, nor while a run streams out;
//   busy rises when the 2-entry queue fills. The receiver cannot stall results.
// Synchronous active-low reset empties the queue, clears the store count and overflow mark.
// ----------------------------------------------------------------------------
// binary_insertion_sorter_unit
// Sorts a set of signed values into ascending order and streams them out.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_insertion_sorter_unit #(
  parameter int DEPTH      = bis_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bis_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [bis_pkg::VALUE_W-1:0] in_value,
  input  wire logic                               in_is_last,
  output logic                                    out_valid,
  output logic signed [bis_pkg::VALUE_W-1:0]      out_sorted_value,
  output logic                                    out_last_of_run,
  output logic                                    out_overflow
);

  logic           q_valid;
  logic           q_pop;
  bis_pkg::item_t q_item;

  bis_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_value   (in_value),
    .in_is_last (in_is_last),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  bis_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_last_of_run  (out_last_of_run),
    .out_overflow     (out_overflow)
  );

endmodule

`default_nettype wire

/* rtl/core/bis_checker.sv */
// ----------------------------------------------------------------------------
// bis_checker
// Port-level checks on the sorter's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               busy,
  input wire logic                               out_valid,
  input wire logic signed [bis_pkg::VALUE_W-1:0] out_sorted_value,
  input wire logic                               out_last_of_run,
  input wire logic                               out_overflow
);

  a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_of_run |-> out_valid)
    else $error("last_of_run without a result beat");

  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |=> out_valid && $stable(out_overflow))
    else $error("result run broken or overflow changed mid-run");

  a_gap_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |=> !out_valid)
    else $error("result beat right after end of run");

  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |=> !(out_sorted_value < $past(out_sorted_value)) ||
      out_overflow)
    else $error("results not ascending");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("busy or result after reset");

endmodule

bind binary_insertion_sorter_unit bis_checker u_bis_checker (.*);

`default_nettype wire
